// File: rtl/sha256_message_hash_unit_defines.svh
// assertion macros for the sha-256 hash unit checker
// no dependencies
`ifndef SHA256_MESSAGE_HASH_UNIT_DEFINES_SVH
`define SHA256_MESSAGE_HASH_UNIT_DEFINES_SVH
// implication checked on every clock edge outside reset
`define SHA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define SHA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

// File: rtl/sha_pkg.sv
// package for the sha-256 hash unit: round constants, initial hash, state codes
// no dependencies
`default_nettype none
package sha_pkg;
	localparam int unsigned WordW = 32;

	typedef logic [WordW-1:0] word_t;

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_PAD    = 6'b000010,
		ST_ROUND  = 6'b000100,
		ST_FOLD   = 6'b001000,
		ST_OUT    = 6'b010000,
		ST_CLEAR  = 6'b100000
	} state_t;

	localparam word_t InitHash [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam word_t RoundK [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	function automatic word_t rotr(input word_t v, input int unsigned n);
		rotr = (v >> n) | (v << (WordW - n));
	endfunction
endpackage
`default_nettype wire

// File: rtl/sha256_message_hash_unit.sv
// sha-256 message hash unit: word intake, padding, 64-round compression, digest output
// depends on sha_pkg
// Message words are taken one per request while a block fills. When the
// sixteenth word of a block is in, the input stalls for the compression: one
// shared round unit runs 64 rounds, one a cycle, then a fold step adds the
// working variables into the chaining hash. On the last word the padding
// words go in one a cycle (up to two blocks, with a compression between
// them), then the eight digest words are offered on the master side, one per
// request; the next message is accepted after a clear state resets the hash.
`default_nettype none
module sha256_message_hash_unit
	import sha_pkg::*;
(
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [39:0] s_tdata,  // data_word[31:0], byte_count[34:32], zeros
	input  wire         s_tlast,  // last_word
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [39:0] m_tdata,  // digest_word[31:0], word_index[34:32], zeros
	output logic        m_tlast   // last_digest
);
	state_t      state_q;
	word_t       hash_q [8];
	word_t       var_q  [8];
	word_t       win_q  [16];
	logic [3:0]  fill_q;
	logic [63:0] bits_q;
	logic        marker_q;
	logic [5:0]  round_q;
	logic        final_q;
	logic [2:0]  out_q;
	state_t      after_q;

	// input word shaping
	logic [2:0] bytes;
	word_t      in_word;
	word_t      keep;
	always_comb begin
		bytes = (s_tdata[34:32] > 3'd4 || !s_tlast) ? 3'd4 : s_tdata[34:32];
		unique case (bytes)
			3'd0: keep = 32'h0;
			3'd1: keep = 32'hff000000;
			3'd2: keep = 32'hffff0000;
			3'd3: keep = 32'hffffff00;
			default: keep = 32'hffffffff;
		endcase
		if (bytes == 3'd4) begin
			in_word = s_tdata[31:0];
		end else begin
			in_word = (s_tdata[31:0] & keep) | (32'h80 << (5'd24 - {bytes[1:0], 3'b000}));
		end
	end

	// padding word for the current slot
	word_t pad_word;
	always_comb begin
		if (!marker_q) begin
			pad_word = 32'h80000000;
		end else if (fill_q == 4'd14) begin
			pad_word = bits_q[63:32];
		end else if (fill_q == 4'd15 && final_q) begin
			pad_word = bits_q[31:0];
		end else begin
			pad_word = '0;
		end
	end

	// shared round unit and schedule expansion
	word_t w15, w2, s0, s1, w_new, w_use, t1, t2, ea, eb, ch, maj;
	always_comb begin
		w15 = win_q[4'(round_q[3:0] + 4'd1)];
		w2  = win_q[4'(round_q[3:0] + 4'd14)];
		s0 = rotr(w15, 7) ^ rotr(w15, 18) ^ (w15 >> 3);
		s1 = rotr(w2, 17) ^ rotr(w2, 19) ^ (w2 >> 10);
		w_new = win_q[round_q[3:0]] + s0 + win_q[4'(round_q[3:0] + 4'd9)] + s1;
		w_use = (round_q < 6'd16) ? win_q[round_q[3:0]] : w_new;
		ea = rotr(var_q[4], 6) ^ rotr(var_q[4], 11) ^ rotr(var_q[4], 25);
		ch = (var_q[4] & var_q[5]) ^ (~var_q[4] & var_q[6]);
		t1 = var_q[7] + ea + ch + RoundK[round_q] + w_use;
		eb = rotr(var_q[0], 2) ^ rotr(var_q[0], 13) ^ rotr(var_q[0], 22);
		maj = (var_q[0] & var_q[1]) ^ (var_q[0] & var_q[2]) ^ (var_q[1] & var_q[2]);
		t2 = eb + maj;
	end

	assign s_tready = state_q == ST_IDLE;
	assign m_tvalid = state_q == ST_OUT;
	assign m_tdata  = {5'd0, out_q, hash_q[out_q]};
	assign m_tlast  = out_q == 3'd7;

	logic  push;
	word_t push_word;
	always_comb begin
		push = (state_q == ST_IDLE && s_tvalid) || state_q == ST_PAD;
		push_word = (state_q == ST_PAD) ? pad_word : in_word;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			win_q[fill_q] <= push_word;
		end else if (state_q == ST_ROUND && round_q >= 6'd16) begin
			win_q[round_q[3:0]] <= w_new;
		end
		if (push && fill_q == 4'd15) begin
			for (int i = 0; i < 8; i++) var_q[i] <= hash_q[i];
		end else if (state_q == ST_ROUND) begin
			var_q[7] <= var_q[6];
			var_q[6] <= var_q[5];
			var_q[5] <= var_q[4];
			var_q[4] <= var_q[3] + t1;
			var_q[3] <= var_q[2];
			var_q[2] <= var_q[1];
			var_q[1] <= var_q[0];
			var_q[0] <= t1 + t2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			after_q  <= ST_IDLE;
			for (int i = 0; i < 8; i++) hash_q[i] <= InitHash[i];
			fill_q   <= '0;
			bits_q   <= '0;
			marker_q <= 1'b0;
			round_q  <= '0;
			final_q  <= 1'b0;
			out_q    <= '0;
		end else begin
			if (push) begin
				fill_q <= 4'(fill_q + 4'd1);
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						bits_q <= bits_q + 64'({bytes, 3'b000});
						if (bytes != 3'd4) marker_q <= 1'b1;
						final_q <= 1'b0;
						after_q <= s_tlast ? ST_PAD : ST_IDLE;
						if (fill_q == 4'd15) begin
							round_q <= '0;
							state_q <= ST_ROUND;
						end else if (s_tlast) begin
							state_q <= ST_PAD;
						end
					end
				end
				ST_PAD: begin
					marker_q <= 1'b1;
					// length high word went into slot 14, so slot 15 takes the low word
					final_q <= fill_q == 4'd14 && marker_q;
					if (fill_q == 4'd15) begin
						round_q <= '0;
						after_q <= final_q ? ST_OUT : ST_PAD;
						state_q <= ST_ROUND;
					end
				end
				ST_ROUND: begin
					round_q <= 6'(round_q + 6'd1);
					if (round_q == 6'd63) state_q <= ST_FOLD;
				end
				ST_FOLD: begin
					for (int i = 0; i < 8; i++) hash_q[i] <= hash_q[i] + var_q[i];
					out_q   <= '0;
					state_q <= after_q;
				end
				ST_OUT: begin
					if (m_tready) begin
						out_q <= 3'(out_q + 3'd1);
						if (out_q == 3'd7) state_q <= ST_CLEAR;
					end
				end
				ST_CLEAR: begin
					for (int i = 0; i < 8; i++) hash_q[i] <= InitHash[i];
					fill_q   <= '0;
					bits_q   <= '0;
					marker_q <= 1'b0;
					final_q  <= 1'b0;
					after_q  <= ST_IDLE;
					state_q  <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// File: rtl/sha_checker.sv
// port-level checker for the sha-256 hash unit, bound to the top level
// depends on sha256_message_hash_unit_defines.svh
`default_nettype none
`include "sha256_message_hash_unit_defines.svh"
module sha_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        s_tready,
	input wire        m_tvalid,
	input wire        m_tready,
	input wire [39:0] m_tdata,
	input wire        m_tlast
);
	// digest output and input intake never overlap
	`SHA_ASSERT_IMP(a_excl, clk, arst_n, m_tvalid, !s_tready, "input open during digest output")
	// last flag only on index seven
	`SHA_ASSERT_IMP(a_last, clk, arst_n, m_tvalid, m_tlast == (m_tdata[34:32] == 3'd7), "bad last")
	// index steps by one per taken request within a digest
	`SHA_ASSERT_NEXT(a_step, clk, arst_n, m_tvalid && m_tready && !m_tlast,
		m_tvalid && m_tdata[34:32] == $past(m_tdata[34:32]) + 3'd1, "index skipped")
	// a digest starts at index zero
	`SHA_ASSERT_IMP(a_zero, clk, arst_n, $rose(m_tvalid), m_tdata[34:32] == 3'd0, "start not zero")
endmodule

bind sha256_message_hash_unit sha_checker u_sha_checker (
	.clk(clk), .arst_n(arst_n), .s_tready(s_tready), .m_tvalid(m_tvalid),
	.m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
);
`default_nettype wire
